@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every rising clock edge outside reset.
`define AST_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Same-cycle implication.
`define AST_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hdol_pkg.sv @@
package hdol_pkg;

    localparam int TEMP_BITS_DEF = 12;
    localparam int CFG_IDX_BITS  = 3;
    localparam int DRIVE_BITS    = 8;
    localparam int PCT_BITS      = 7;
    localparam int PCT_MAX       = 100;

    // shortfall * 500 / target
    localparam int DIV_SCALE     = 500;
    localparam int SCALE_BITS    = 9;

    // floor(255 * p / 100) == (p * DRV_RECIP) >> DRV_SHIFT for p in 0..100
    localparam int DRV_RECIP     = 167117;
    localparam int RECIP_BITS    = 18;
    localparam int DRV_SHIFT     = 16;

    localparam int RST_VALID_MIN = 0;
    localparam int RST_TARGET    = 400;
    localparam int RST_THRESH    = 8;
    localparam int RST_PLATE_MAX = 1280;
    localparam int RST_RESTART   = 960;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_VALID_MIN = 3'd0,
        CFG_TARGET    = 3'd1,
        CFG_THRESH    = 3'd2,
        CFG_PLATE_MAX = 3'd3,
        CFG_RESTART   = 3'd4
    } cfg_idx_t;

endpackage

@@ hdl/heater_drive_with_overtemp_latch.sv @@
// A sample is taken in ST_IDLE, divided in ST_DIV and registered to the outputs in ST_DONE.
// No new sample is taken until its result is in the output register; the bit-serial restoring
// divider shifts one dividend bit per cycle for shortfall * 500 / target.
// Result sits in an output register; the next item is taken while it waits.
// Reset (rst_n, async, active low): registers to their defaults, latch set
// (heating disabled), no result pending.
module heater_drive_with_overtemp_latch #(
    parameter int TEMP_BITS = hdol_pkg::TEMP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hdol_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [TEMP_BITS-1:0]                cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [TEMP_BITS-1:0]         water_temp,
    input  logic signed [TEMP_BITS-1:0]         plate_temp,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hdol_pkg::DRIVE_BITS-1:0]     drive_level,
    output logic [hdol_pkg::PCT_BITS-1:0]       power_percent,
    output logic                                heat_latched_off,
    output logic                                sensor_fault
);
    import hdol_pkg::*;

    localparam int DW        = TEMP_BITS + SCALE_BITS;
    localparam int CNT_BITS  = $clog2(DW + 1);
    localparam int PROD_BITS = PCT_BITS + RECIP_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

    // configuration registers
    logic signed [TEMP_BITS-1:0] valid_min_reg;
    logic [TEMP_BITS-2:0]        target_reg;
    logic [TEMP_BITS-2:0]        thresh_reg;
    logic signed [TEMP_BITS-1:0] plate_max_reg;
    logic signed [TEMP_BITS-1:0] restart_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_min_reg <= TEMP_BITS'(RST_VALID_MIN);
            target_reg    <= (TEMP_BITS-1)'(RST_TARGET);
            thresh_reg    <= (TEMP_BITS-1)'(RST_THRESH);
            plate_max_reg <= TEMP_BITS'(RST_PLATE_MAX);
            restart_reg   <= TEMP_BITS'(RST_RESTART);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VALID_MIN: valid_min_reg <= cfg_data;
                CFG_TARGET:    target_reg    <= cfg_data[TEMP_BITS-2:0];
                CFG_THRESH:    thresh_reg    <= cfg_data[TEMP_BITS-2:0];
                CFG_PLATE_MAX: plate_max_reg <= cfg_data;
                CFG_RESTART:   restart_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [DW-1:0]          num_reg, num_next;
    logic [TEMP_BITS-2:0]   rem_reg, rem_next;
    logic [PCT_BITS-1:0]    quo_reg, quo_next;
    logic                   ovf_reg, ovf_next;
    logic                   heat_reg, heat_next;
    logic                   fault_reg, fault_next;
    logic                   latch_reg, latch_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DRIVE_BITS-1:0]  drive_reg, drive_next;
    logic [PCT_BITS-1:0]    pct_reg, pct_next;
    logic                   latched_reg, latched_next;
    logic                   fault_out_reg, fault_out_next;

    // front end, evaluated on the accepting edge
    logic                       accept;
    logic                       fault_c;
    logic signed [TEMP_BITS:0]  short_c;
    logic                       heat_c;
    logic [DW-1:0]              dividend_c;

    assign accept  = in_valid && !in_stall;
    assign fault_c = (water_temp < valid_min_reg) || (plate_temp < valid_min_reg);
    assign short_c = $signed({2'b00, target_reg}) - $signed({water_temp[TEMP_BITS-1], water_temp});
    assign heat_c  = !fault_c && (short_c > $signed({2'b00, thresh_reg}));
    // shortfall is positive whenever it matters, and below 2^TEMP_BITS
    assign dividend_c = {{SCALE_BITS{1'b0}}, short_c[TEMP_BITS-1:0]} * DW'(DIV_SCALE);

    // one restoring step per cycle
    logic [TEMP_BITS-1:0] trial;
    logic                 ge;
    logic [TEMP_BITS-1:0] diff;

    assign trial = {rem_reg, num_reg[DW-1]};
    assign ge    = trial >= {1'b0, target_reg};
    assign diff  = trial - {1'b0, target_reg};

    // result stage
    logic [PCT_BITS-1:0]  pct_c;
    logic [PROD_BITS-1:0] prod_c;

    always_comb
    begin
        if (!heat_reg)
            pct_c = '0;
        else if (ovf_reg || quo_reg > PCT_BITS'(PCT_MAX))
            pct_c = PCT_BITS'(PCT_MAX);
        else
            pct_c = quo_reg;
    end

    assign prod_c = {{RECIP_BITS{1'b0}}, pct_c} * PROD_BITS'(DRV_RECIP);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        ovf_next       = ovf_reg;
        heat_next      = heat_reg;
        fault_next     = fault_reg;
        latch_next     = latch_reg;
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        pct_next       = pct_reg;
        latched_next   = latched_reg;
        fault_out_next = fault_out_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    num_next   = dividend_c;
                    rem_next   = '0;
                    quo_next   = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = '0;
                    heat_next  = heat_c;
                    fault_next = fault_c;
                    // latch updates on every transaction, max test first
                    if (plate_temp > plate_max_reg)
                        latch_next = 1'b1;
                    else if (plate_temp < restart_reg)
                        latch_next = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                num_next = {num_reg[DW-2:0], 1'b0};
                rem_next = ge ? diff[TEMP_BITS-2:0] : trial[TEMP_BITS-2:0];
                quo_next = {quo_reg[PCT_BITS-2:0], ge};
                ovf_next = ovf_reg | quo_reg[PCT_BITS-1];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DW - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    pct_next       = pct_c;
                    drive_next     = latch_reg ? '0
                                     : prod_c[DRV_SHIFT+DRIVE_BITS-1:DRV_SHIFT];
                    latched_next   = latch_reg;
                    fault_out_next = fault_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            ovf_reg       <= 1'b0;
            heat_reg      <= 1'b0;
            fault_reg     <= 1'b0;
            latch_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            pct_reg       <= '0;
            latched_reg   <= 1'b0;
            fault_out_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            num_reg       <= num_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            ovf_reg       <= ovf_next;
            heat_reg      <= heat_next;
            fault_reg     <= fault_next;
            latch_reg     <= latch_next;
            out_valid_reg <= out_valid_next;
            drive_reg     <= drive_next;
            pct_reg       <= pct_next;
            latched_reg   <= latched_next;
            fault_out_reg <= fault_out_next;
        end
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign drive_level      = drive_reg;
    assign power_percent    = pct_reg;
    assign heat_latched_off = latched_reg;
    assign sensor_fault     = fault_out_reg;

endmodule

@@ hdl/hdol_checker.sv @@
`include "assert_macros.svh"

module hdol_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [hdol_pkg::DRIVE_BITS-1:0] drive_level,
    input logic [hdol_pkg::PCT_BITS-1:0]   power_percent,
    input logic                            heat_latched_off,
    input logic                            sensor_fault
);
    import hdol_pkg::*;

    // drive only when heating is allowed and requested
    `AST_IMPL(a_drive_gated, clk, rst_n, out_valid && drive_level != '0, !heat_latched_off && power_percent != '0, "drive with latch set or zero percent")
    `AST_IMPL(a_pct_range, clk, rst_n, out_valid, power_percent <= PCT_BITS'(PCT_MAX), "percent above 100")
    `AST_IMPL(a_fault_no_power, clk, rst_n, out_valid && sensor_fault, power_percent == '0, "power requested on sensor fault")
    // sequential block: busy right after taking a transaction
    `AST_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accepted back to back")
    `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(drive_level) && $stable(power_percent) && $stable(heat_latched_off) && $stable(sensor_fault), "stalled result changed")

endmodule

bind heater_drive_with_overtemp_latch hdol_checker u_hdol_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_level      (drive_level),
    .power_percent    (power_percent),
    .heat_latched_off (heat_latched_off),
    .sensor_fault     (sensor_fault)
);

@@ tb/sv/heater_drive_with_overtemp_latch_tb.sv @@
module heater_drive_with_overtemp_latch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hdol_pkg::*;

    localparam int TEMP_W         = TEMP_BITS_DEF;
    localparam int TEMP_MAX       = 2 ** (TEMP_W - 1) - 1;
    localparam int TEMP_MIN       = -(2 ** (TEMP_W - 1));
    localparam int DRIVE_FULL     = 2 ** DRIVE_BITS - 1;
    localparam int GAP_MAX        = 12;
    localparam int SETTLE_CYCLES  = TEMP_W + 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 13;
    localparam int PHASE_ITEMS    = 50;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NONE_FIRST = CFG_IDX_BITS'(CFG_RESTART + 1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONE_LAST  = '1;

    typedef struct packed {
        logic [DRIVE_BITS-1:0] drive;
        logic [PCT_BITS-1:0]   percent;
        logic                  latched;
        logic                  fault;
    } heat_result_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_BITS-1:0] index;
        logic [TEMP_W-1:0]       data;
        logic signed [TEMP_W-1:0] water;
        logic signed [TEMP_W-1:0] plate;
        bit                      typed;
        heat_result_t            want;
    } plan_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_BITS-1:0]      cfg_index;
    logic [TEMP_W-1:0]            cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [TEMP_W-1:0]     water_temp;
    logic signed [TEMP_W-1:0]     plate_temp;
    logic                         out_valid;
    logic                         out_stall;
    logic [DRIVE_BITS-1:0]        drive_level;
    logic [PCT_BITS-1:0]          power_percent;
    logic                         heat_latched_off;
    logic                         sensor_fault;

    // shadow copy of the block's registers and latch
    logic signed [TEMP_W-1:0]     sh_valid_min;
    logic [TEMP_W-2:0]            sh_target;
    logic [TEMP_W-2:0]            sh_thresh;
    logic signed [TEMP_W-1:0]     sh_plate_max;
    logic signed [TEMP_W-1:0]     sh_restart;
    logic                         sh_latch;

    heat_result_t                 expected_heat[$];
    plan_row_t                    plan[$];

    int  mismatch_count = 0;
    int  sample_count   = 0;
    int  result_count   = 0;
    int  write_count    = 0;
    int  settings_count = 0;
    int  quiet_cycles   = 0;
    int  stall_left     = 0;
    bit  in_gaps_on     = 1'b1;
    bit  out_stalls_on  = 1'b1;

    heater_drive_with_overtemp_latch u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .water_temp       (water_temp),
        .plate_temp       (plate_temp),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_level      (drive_level),
        .power_percent    (power_percent),
        .heat_latched_off (heat_latched_off),
        .sensor_fault     (sensor_fault)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int clamp_temp(input int v);
        if (v > TEMP_MAX)
            return TEMP_MAX;
        if (v < TEMP_MIN)
            return TEMP_MIN;
        return v;
    endfunction

    function automatic void reset_shadow();
        sh_valid_min = TEMP_W'(RST_VALID_MIN);
        sh_target    = (TEMP_W-1)'(RST_TARGET);
        sh_thresh    = (TEMP_W-1)'(RST_THRESH);
        sh_plate_max = TEMP_W'(RST_PLATE_MAX);
        sh_restart   = TEMP_W'(RST_RESTART);
        sh_latch     = 1'b1;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [TEMP_W-1:0] data);
        case (cfg_idx_t'(idx))
            CFG_VALID_MIN: sh_valid_min = data;
            CFG_TARGET:    sh_target    = data[TEMP_W-2:0];
            CFG_THRESH:    sh_thresh    = data[TEMP_W-2:0];
            CFG_PLATE_MAX: sh_plate_max = data;
            CFG_RESTART:   sh_restart   = data;
            default:       ;
        endcase
    endfunction

    // proportional demand plus hysteresis cutoff; updates the shadow latch
    function automatic heat_result_t predict_heat(input logic signed [TEMP_W-1:0] w,
                                                  input logic signed [TEMP_W-1:0] p);
        heat_result_t r;
        int shortfall;
        int pct;
        r.fault = (w < sh_valid_min) || (p < sh_valid_min);
        pct = 0;
        if (!r.fault)
        begin
            shortfall = int'(sh_target) - int'(w);
            if (shortfall > int'(sh_thresh))
            begin
                if (sh_target == 0)
                    pct = PCT_MAX;
                else
                begin
                    pct = shortfall * DIV_SCALE / int'(sh_target);
                    if (pct > PCT_MAX)
                        pct = PCT_MAX;
                end
            end
        end
        if (p > sh_plate_max)
            sh_latch = 1'b1;
        else if (sh_latch && p < sh_restart)
            sh_latch = 1'b0;
        r.latched = sh_latch;
        r.percent = PCT_BITS'(pct);
        r.drive   = sh_latch ? '0 : DRIVE_BITS'(DRIVE_FULL * pct / PCT_MAX);
        return r;
    endfunction

    function automatic void plan_write(input logic [CFG_IDX_BITS-1:0] idx, input int data);
        plan_row_t row;
        row.kind  = ROW_WRITE;
        row.index = idx;
        row.data  = TEMP_W'(data);
        row.water = '0;
        row.plate = '0;
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_sample(input int w, input int p);
        plan_row_t row;
        row.kind  = ROW_SAMPLE;
        row.index = '0;
        row.data  = '0;
        row.water = TEMP_W'(w);
        row.plate = TEMP_W'(p);
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_checked(input int w, input int p, input int drive,
                                         input int pct, input bit latched, input bit fault);
        plan_sample(w, p);
        plan[$].typed        = 1'b1;
        plan[$].want.drive   = DRIVE_BITS'(drive);
        plan[$].want.percent = PCT_BITS'(pct);
        plan[$].want.latched = latched;
        plan[$].want.fault   = fault;
    endfunction

    task automatic send_sample(input logic signed [TEMP_W-1:0] w,
                               input logic signed [TEMP_W-1:0] p,
                               input bit typed, input heat_result_t want);
        int gap;
        heat_result_t pred;
        gap = in_gaps_on ? int'($urandom_range(0, GAP_MAX)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        water_temp <= w;
        plate_temp <= p;
        do @(posedge clk); while (in_stall);
        pred = predict_heat(w, p);
        expected_heat.push_back(typed ? want : pred);
        sample_count++;
    endtask

    // caller lowers cfg_valid after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [TEMP_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        write_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_heat.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [TEMP_W-1:0] pick_reg(input cfg_idx_t idx);
        logic [TEMP_W-1:0] hi_bit;
        if ($urandom_range(0, 3) == 0)
            return TEMP_W'($urandom);
        hi_bit = TEMP_W'($urandom_range(0, 1) << (TEMP_W - 1));
        case (idx)
            CFG_VALID_MIN: return TEMP_W'(-int'($urandom_range(0, 400)));
            CFG_TARGET:    return TEMP_W'(int'($urandom_range(200, 1500))) | hi_bit;
            CFG_THRESH:    return TEMP_W'(int'($urandom_range(0, 60))) | hi_bit;
            CFG_PLATE_MAX: return TEMP_W'($urandom_range(900, 1800));
            default:
                return TEMP_W'(clamp_temp(int'(sh_plate_max) - int'($urandom_range(0, 400))));
        endcase
    endfunction

    task automatic program_phase(input int phase);
        cfg_idx_t idx;
        logic [TEMP_W-1:0] data;
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_IDX_BITS'($urandom_range(int'(CFG_NONE_FIRST), int'(CFG_NONE_LAST))),
                      TEMP_W'($urandom));
        idx = CFG_VALID_MIN;
        repeat (CFG_RESTART + 1)
        begin
            case (phase % 4)
                1: data = TEMP_W'((idx == CFG_TARGET) ? 1 : (idx == CFG_THRESH) ? 0 : TEMP_MIN);
                2: data = TEMP_W'(TEMP_MAX);
                default: data = pick_reg(idx);
            endcase
            write_reg(idx, data);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // output side: random stall after each transaction, counted while a result waits
    always @(posedge clk)
    begin : result_check
        heat_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_heat.size() == 0)
            begin
                $error("result with nothing expected: drive %0d percent %0d",
                       drive_level, power_percent);
                mismatch_count++;
            end
            else
            begin
                want = expected_heat.pop_front();
                result_count++;
                if (drive_level !== want.drive)
                begin
                    $error("drive_level: expected %0d, got %0d", want.drive, drive_level);
                    mismatch_count++;
                end
                if (power_percent !== want.percent)
                begin
                    $error("power_percent: expected %0d, got %0d", want.percent, power_percent);
                    mismatch_count++;
                end
                if (heat_latched_off !== want.latched)
                begin
                    $error("heat_latched_off: expected %0d, got %0d",
                           want.latched, heat_latched_off);
                    mismatch_count++;
                end
                if (sensor_fault !== want.fault)
                begin
                    $error("sensor_fault: expected %0d, got %0d", want.fault, sensor_fault);
                    mismatch_count++;
                end
            end
            stall_left = out_stalls_on ? int'($urandom_range(0, GAP_MAX)) : 0;
        end
        else if (stall_left > 0 && out_valid)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", quiet_cycles);
                $display("heater_drive_with_overtemp_latch_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [TEMP_W-1:0] w;
        logic signed [TEMP_W-1:0] p;
        int plate_walk;
        int dir;
        int step;

        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        water_temp <= '0;
        plate_temp <= '0;
        reset_shadow();

        // after reset: latch set, defaults 0 / 400 / 8 / 1280 / 960
        plan_checked(0, 1000, 0, 100, 1, 0);
        plan_checked(0, 0, DRIVE_FULL, 100, 0, 0);
        plan_checked(TEMP_MIN, 0, 0, 0, 0, 1);
        plan_checked(0, TEMP_MIN, 0, 0, 0, 1);
        plan_checked(TEMP_MAX, TEMP_MAX, 0, 0, 1, 0);
        plan_checked(0, 1280, 0, 100, 1, 0);
        plan_checked(0, 959, DRIVE_FULL, 100, 0, 0);
        plan_checked(0, 960, DRIVE_FULL, 100, 0, 0);
        plan_checked(0, 1281, 0, 100, 1, 0);
        plan_checked(392, 0, 0, 0, 0, 0);           // shortfall equals threshold
        plan_sample(391, 0);
        plan_sample(320, 0);
        plan_sample(321, 0);
        plan_write(CFG_VALID_MIN, TEMP_MIN);
        plan_write(CFG_TARGET, 2 ** (TEMP_W - 1) - 1);
        plan_write(CFG_THRESH, 0);
        plan_write(CFG_PLATE_MAX, TEMP_MAX);
        plan_write(CFG_RESTART, TEMP_MIN);
        plan_checked(TEMP_MIN, TEMP_MIN, DRIVE_FULL, 100, 0, 0);
        plan_checked(TEMP_MAX, TEMP_MAX, 0, 0, 0, 0);
        plan_sample(TEMP_MAX - 1, 0);
        // zero target via the ignored top bit; threshold 5 with top bit set
        plan_write(CFG_TARGET, 2 ** (TEMP_W - 1));
        plan_write(CFG_THRESH, 2 ** (TEMP_W - 1) + 5);
        plan_write(CFG_RESTART, TEMP_MAX);
        plan_checked(-6, 0, DRIVE_FULL, 100, 0, 0);
        plan_checked(-5, 0, 0, 0, 0, 0);
        plan_write(CFG_VALID_MIN, TEMP_MAX);
        plan_write(CFG_PLATE_MAX, TEMP_MIN);
        plan_write(CFG_RESTART, TEMP_MIN);
        plan_checked(TEMP_MAX, TEMP_MAX, 0, 0, 1, 0);
        plan_checked(TEMP_MAX, TEMP_MAX - 1, 0, 0, 1, 1);
        plan_checked(TEMP_MAX, TEMP_MIN, 0, 0, 1, 1);
        // max below restart: set wins inside the overlap
        plan_write(CFG_VALID_MIN, TEMP_MIN);
        plan_write(CFG_PLATE_MAX, 0);
        plan_write(CFG_RESTART, 100);
        plan_write(CFG_NONE_FIRST, 12'h5A5);
        plan_write(CFG_NONE_LAST, 12'hA5A);
        plan_checked(0, 50, 0, 0, 1, 0);
        plan_checked(0, -1, 0, 0, 0, 0);
        plan_sample(-200, 300);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        settings_count = 1;

        for (int r = 0; r < plan.size(); r++)
        begin
            if (plan[r].kind == ROW_WRITE)
            begin
                if (r == 0 || plan[r-1].kind != ROW_WRITE)
                begin
                    drain();
                    settings_count++;
                end
                write_reg(plan[r].index, plan[r].data);
                if (r + 1 == plan.size() || plan[r+1].kind != ROW_WRITE)
                    cfg_valid <= 1'b0;
            end
            else
                send_sample(plan[r].water, plan[r].plate, plan[r].typed, plan[r].want);
        end

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            drain();
            program_phase(phase);
            in_gaps_on    = ($urandom_range(0, 2) != 0);
            out_stalls_on = ($urandom_range(0, 2) != 0);
            plate_walk    = int'(sh_restart);
            dir           = 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    w = TEMP_W'($urandom);
                    p = TEMP_W'($urandom);
                end
                else
                begin
                    // plate sweeps across restart and max so the latch keeps toggling
                    step = int'($urandom_range(0, 50)) - 10;
                    plate_walk = clamp_temp(plate_walk + dir * step);
                    if (plate_walk > int'(sh_plate_max) + 40 || plate_walk >= TEMP_MAX)
                        dir = -1;
                    else if (plate_walk < int'(sh_restart) - 40 || plate_walk <= TEMP_MIN)
                        dir = 1;
                    p = TEMP_W'(plate_walk);
                    if ($urandom_range(0, 15) == 0)
                        w = TEMP_W'(clamp_temp(int'(sh_valid_min) - 1
                                               - int'($urandom_range(0, 20))));
                    else
                        w = TEMP_W'(clamp_temp(int'(sh_target)
                                               - (int'($urandom_range(0, 700)) - 100)));
                end
                send_sample(w, p, 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d samples under %0d register settings (%0d writes)",
                 sample_count, settings_count, write_count);
        $display("%0d results compared, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0)
            $display("heater_drive_with_overtemp_latch_tb: done, clean");
        else
            $display("heater_drive_with_overtemp_latch_tb: done, errors");
        $finish;
    end

endmodule
